/* src/cpb_pkg.sv */
package cpb_pkg;

   // Fixed field widths
   localparam int IDX_W = 13;
   localparam int OP_W = 3;
   localparam int POS_W = IDX_W + 1;
   localparam int IDX_LIMIT = (1 << IDX_W) - 1;

   // Bitmap row geometry
   localparam int WORD_W = 32;
   localparam int OFF_W = 5;

   // Row tag: epoch numbers run 1..TAG_LAST, tag zero marks a swept row
   localparam int TAG_W = 8;
   localparam logic [TAG_W-1:0] TAG_NONE = 8'h00;
   localparam logic [TAG_W-1:0] TAG_FIRST = 8'h01;
   localparam logic [TAG_W-1:0] TAG_LAST = 8'hff;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW = 1;

   // Operation codes on the request port
   typedef enum logic [OP_W-1:0] {
      OP_QUERY = 3'd0,
      OP_SET = 3'd1,
      OP_UNSET = 3'd2,
      OP_SET_ALL = 3'd3,
      OP_CLEAR_ALL = 3'd4
   } op_type;

   // Classified work for the back end
   typedef enum logic [2:0] {
      KIND_QUERY,
      KIND_SET,
      KIND_UNSET,
      KIND_SET_ALL,
      KIND_CLEAR_ALL
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic in_range;
      logic [IDX_W-1:0] idx;
   } item_type;

   // Back end sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MODIFY,
      ST_START,
      ST_SRCH_RD,
      ST_SRCH_EV
   } state_type;

endpackage

/* src/chunk_presence_bitmap_unit.sv */
// Channel   Direction  Ports                                    Handshake
// request   in         req_operation, req_chunk_index           start / busy
// response  out        rsp_is_held, rsp_held_total,             rsp_valid, one cycle
//                      rsp_next_missing
// csr       in/out     psel, penable, pwrite, paddr, pwdata,    APB, pready tied high
//                      prdata, pready
//
// With the back end idle a transaction runs through EXEC and START, adding MODIFY for a mark
// inside the count, then for an index inside the count a SRCH_RD and SRCH_EV pair for every
// 32-chunk bitmap row the search reads up to the first missing chunk or the end of the count,
// one row at a time through the single bitmap read port. Reset starts a clearing pass of one
// row per cycle with busy high, and the same pass follows every 255th bulk mark, clear or count
// write. A two-entry queue takes start while the back end works; the receiver cannot stall.
module chunk_presence_bitmap_unit #(
   parameter int MAX_CHUNKS = 4096
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [cpb_pkg::OP_W-1:0] req_operation,
   input  logic [cpb_pkg::IDX_W-1:0] req_chunk_index,
   output logic rsp_valid,
   output logic rsp_is_held,
   output logic [cpb_pkg::IDX_W-1:0] rsp_held_total,
   output logic [cpb_pkg::IDX_W-1:0] rsp_next_missing,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [2:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);

   localparam int IW = cpb_pkg::IDX_W;

   logic [IW-1:0] chunk_total_ff, chunk_total_in;
   logic [IW-1:0] live_total;
   logic csr_write;
   logic wipe;
   logic push;
   cpb_pkg::item_type push_item;
   logic queue_full;
   logic queue_empty;
   logic queue_pop;
   cpb_pkg::item_type queue_item;
   logic sweeping;

   // Register file: chunk count at index 0
   assign pready = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign wipe = csr_write & (paddr[2] == 1'b0);
   assign chunk_total_in = wipe ? pwdata[IW-1:0] : chunk_total_ff;
   assign prdata = (paddr[2] == 1'b0) ? {{(32 - IW){1'b0}}, chunk_total_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_total_ff <= '0;
      end else begin
         chunk_total_ff <= chunk_total_in;
      end
   end

   // Saturate the count at the capacity
   assign live_total = (32'(chunk_total_ff) > 32'(MAX_CHUNKS)) ? IW'(MAX_CHUNKS)
                                                               : chunk_total_ff;

   cpb_front u_front (
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_chunk_index(req_chunk_index),
      .live_total(live_total),
      .queue_full(queue_full),
      .sweeping(sweeping),
      .push(push),
      .push_item(push_item)
   );

   cpb_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_item(push_item),
      .full(queue_full),
      .pop(queue_pop),
      .pop_item(queue_item),
      .empty(queue_empty)
   );

   cpb_back #(
      .MAX_CHUNKS(MAX_CHUNKS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .wipe(wipe),
      .live_total(live_total),
      .queue_empty(queue_empty),
      .queue_item(queue_item),
      .queue_pop(queue_pop),
      .sweeping(sweeping),
      .rsp_valid(rsp_valid),
      .rsp_is_held(rsp_is_held),
      .rsp_held_total(rsp_held_total),
      .rsp_next_missing(rsp_next_missing)
   );

endmodule

/* src/cpb_front.sv */
module cpb_front (
   input  logic start,
   output logic busy,
   input  logic [cpb_pkg::OP_W-1:0] req_operation,
   input  logic [cpb_pkg::IDX_W-1:0] req_chunk_index,
   input  logic [cpb_pkg::IDX_W-1:0] live_total,
   input  logic queue_full,
   input  logic sweeping,
   output logic push,
   output cpb_pkg::item_type push_item
);

   // Hold off new transactions while the queue is full or the store is swept
   assign busy = queue_full | sweeping;
   assign push = start & ~busy;

   // Classify the operation and the range of the index
   always_comb begin
      push_item.idx = req_chunk_index;
      push_item.in_range = (req_chunk_index < live_total);
      case (req_operation)
         cpb_pkg::OP_SET: push_item.kind = cpb_pkg::KIND_SET;
         cpb_pkg::OP_UNSET: push_item.kind = cpb_pkg::KIND_UNSET;
         cpb_pkg::OP_SET_ALL: push_item.kind = cpb_pkg::KIND_SET_ALL;
         cpb_pkg::OP_CLEAR_ALL: push_item.kind = cpb_pkg::KIND_CLEAR_ALL;
         default: push_item.kind = cpb_pkg::KIND_QUERY;
      endcase
   end

endmodule

/* src/cpb_queue.sv */
module cpb_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  cpb_pkg::item_type push_item,
   output logic full,
   input  logic pop,
   output cpb_pkg::item_type pop_item,
   output logic empty
);

   localparam int AW = cpb_pkg::QUEUE_AW;
   localparam int CW = cpb_pkg::QUEUE_AW + 1;

   cpb_pkg::item_type slot_ff [cpb_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full = (count_ff == CW'(cpb_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* src/cpb_back.sv */
module cpb_back #(
   parameter int MAX_CHUNKS = 4096
) (
   input  logic clock,
   input  logic reset,
   input  logic wipe,
   input  logic [cpb_pkg::IDX_W-1:0] live_total,
   input  logic queue_empty,
   input  cpb_pkg::item_type queue_item,
   output logic queue_pop,
   output logic sweeping,
   output logic rsp_valid,
   output logic rsp_is_held,
   output logic [cpb_pkg::IDX_W-1:0] rsp_held_total,
   output logic [cpb_pkg::IDX_W-1:0] rsp_next_missing
);

   localparam int IW = cpb_pkg::IDX_W;
   localparam int PW = cpb_pkg::POS_W;
   localparam int WW = cpb_pkg::WORD_W;
   localparam int OW = cpb_pkg::OFF_W;
   localparam int TW = cpb_pkg::TAG_W;
   localparam int CAP = (MAX_CHUNKS < cpb_pkg::IDX_LIMIT) ? MAX_CHUNKS : cpb_pkg::IDX_LIMIT;
   localparam int ROWS = (CAP + WW - 1) / WW;
   localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;

   // Bitmap rows, each with the epoch it was last written in
   logic [TW+WW-1:0] mem [ROWS];
   logic [TW+WW-1:0] rd_q_ff;
   logic mem_rd_en;
   logic [RAW-1:0] mem_rd_addr;
   logic mem_wr_en;
   logic [RAW-1:0] mem_wr_addr;
   logic [TW+WW-1:0] mem_wr_data;

   cpb_pkg::state_type state_ff, state_in;
   cpb_pkg::item_type item_ff, item_in;
   logic [TW-1:0] epoch_ff, epoch_in;
   logic base_ff, base_in;
   logic [IW-1:0] held_ff, held_in;
   logic sweep_ff, sweep_in;
   logic [RAW-1:0] sweep_row_ff, sweep_row_in;
   logic [RAW-1:0] cur_row_ff, cur_row_in;
   logic first_ff, first_in;
   logic is_held_ff, is_held_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_is_held_ff, rsp_is_held_in;
   logic [IW-1:0] rsp_held_total_ff, rsp_held_total_in;
   logic [IW-1:0] rsp_next_missing_ff, rsp_next_missing_in;

   logic [WW-1:0] row_word;
   logic [RAW-1:0] idx_row;
   logic [OW-1:0] idx_off;
   logic [WW-1:0] idx_bit;
   logic [WW-1:0] low_mask;
   logic [WW-1:0] masked;
   logic zero_found;
   logic [OW-1:0] zero_off;
   logic [PW-1:0] row_base;
   logic [PW-1:0] cand;
   logic [PW-1:0] total_pos;
   logic bump;
   logic mod_wr;

   assign sweeping = sweep_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_is_held = rsp_is_held_ff;
   assign rsp_held_total = rsp_held_total_ff;
   assign rsp_next_missing = rsp_next_missing_ff;

   // Resolve a stale row to the bulk fill value
   assign row_word = (rd_q_ff[TW+WW-1:WW] == epoch_ff) ? rd_q_ff[WW-1:0] : {WW{base_ff}};
   assign idx_row = RAW'(32'(item_ff.idx) >> OW);
   assign idx_off = item_ff.idx[OW-1:0];
   assign idx_bit = WW'(1) << idx_off;
   assign low_mask = idx_bit - WW'(1);
   assign masked = first_ff ? (row_word | low_mask) : row_word;
   assign row_base = PW'(32'(cur_row_ff) << OW);
   assign total_pos = PW'(live_total);

   // Find the lowest missing bit of the row
   always_comb begin
      zero_found = 1'b0;
      zero_off = '0;
      for (int b = WW - 1; b >= 0; b--) begin
         if (!masked[b]) begin
            zero_found = 1'b1;
            zero_off = OW'(b);
         end
      end
   end

   assign cand = row_base + (zero_found ? PW'(zero_off) : PW'(WW));

   // Sequence one transaction: modify, then scan rows for a missing chunk if in range
   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      base_in = base_ff;
      held_in = held_ff;
      cur_row_in = cur_row_ff;
      first_in = first_ff;
      is_held_in = is_held_ff;
      rsp_valid_in = 1'b0;
      rsp_is_held_in = rsp_is_held_ff;
      rsp_held_total_in = rsp_held_total_ff;
      rsp_next_missing_in = rsp_next_missing_ff;
      queue_pop = 1'b0;
      mem_rd_en = 1'b0;
      mem_rd_addr = cur_row_ff;
      mod_wr = 1'b0;
      bump = 1'b0;
      case (state_ff)
         cpb_pkg::ST_IDLE: begin
            if (!queue_empty && !sweep_ff) begin
               queue_pop = 1'b1;
               item_in = queue_item;
               state_in = cpb_pkg::ST_EXEC;
            end
         end
         cpb_pkg::ST_EXEC: begin
            state_in = cpb_pkg::ST_START;
            case (item_ff.kind)
               cpb_pkg::KIND_SET, cpb_pkg::KIND_UNSET: begin
                  if (item_ff.in_range) begin
                     mem_rd_en = 1'b1;
                     mem_rd_addr = idx_row;
                     state_in = cpb_pkg::ST_MODIFY;
                  end
               end
               cpb_pkg::KIND_SET_ALL: begin
                  bump = 1'b1;
                  base_in = 1'b1;
                  held_in = live_total;
               end
               cpb_pkg::KIND_CLEAR_ALL: begin
                  bump = 1'b1;
                  base_in = 1'b0;
                  held_in = '0;
               end
               default: begin
               end
            endcase
         end
         cpb_pkg::ST_MODIFY: begin
            mod_wr = 1'b1;
            if (item_ff.kind == cpb_pkg::KIND_SET && !row_word[idx_off]) begin
               held_in = held_ff + IW'(1);
            end else if (item_ff.kind == cpb_pkg::KIND_UNSET && row_word[idx_off]) begin
               held_in = held_ff - IW'(1);
            end
            state_in = cpb_pkg::ST_START;
         end
         cpb_pkg::ST_START: begin
            if (!sweep_ff) begin
               if (!item_ff.in_range) begin
                  rsp_valid_in = 1'b1;
                  rsp_is_held_in = 1'b0;
                  rsp_held_total_in = held_ff;
                  rsp_next_missing_in = live_total;
                  state_in = cpb_pkg::ST_IDLE;
               end else begin
                  cur_row_in = idx_row;
                  first_in = 1'b1;
                  state_in = cpb_pkg::ST_SRCH_RD;
               end
            end
         end
         cpb_pkg::ST_SRCH_RD: begin
            mem_rd_en = 1'b1;
            mem_rd_addr = cur_row_ff;
            state_in = cpb_pkg::ST_SRCH_EV;
         end
         cpb_pkg::ST_SRCH_EV: begin
            if (first_ff) begin
               is_held_in = row_word[idx_off];
            end
            first_in = 1'b0;
            if (!zero_found && cand < total_pos) begin
               cur_row_in = cur_row_ff + RAW'(1);
               state_in = cpb_pkg::ST_SRCH_RD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_is_held_in = first_ff ? row_word[idx_off] : is_held_ff;
               rsp_held_total_in = held_ff;
               rsp_next_missing_in = (cand >= total_pos) ? live_total : cand[IW-1:0];
               state_in = cpb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cpb_pkg::ST_IDLE;
         end
      endcase
      // A write to the count register wipes the store
      if (wipe) begin
         bump = 1'b1;
         base_in = 1'b0;
         held_in = '0;
      end
   end

   // Retire the current epoch; sweep the tags when the epoch numbers run out
   always_comb begin
      epoch_in = epoch_ff;
      sweep_in = sweep_ff;
      sweep_row_in = sweep_row_ff;
      if (sweep_ff) begin
         sweep_row_in = sweep_row_ff + RAW'(1);
         if (sweep_row_ff == RAW'(ROWS - 1)) begin
            sweep_in = 1'b0;
         end
      end
      if (bump && !sweep_ff) begin
         if (epoch_ff == cpb_pkg::TAG_LAST) begin
            epoch_in = cpb_pkg::TAG_FIRST;
            sweep_in = 1'b1;
            sweep_row_in = '0;
         end else begin
            epoch_in = epoch_ff + TW'(1);
         end
      end
   end

   // Drive the write port
   always_comb begin
      if (sweep_ff) begin
         mem_wr_en = 1'b1;
         mem_wr_addr = sweep_row_ff;
         mem_wr_data = {cpb_pkg::TAG_NONE, {WW{1'b0}}};
      end else begin
         mem_wr_en = mod_wr;
         mem_wr_addr = idx_row;
         if (item_ff.kind == cpb_pkg::KIND_SET) begin
            mem_wr_data = {epoch_ff, row_word | idx_bit};
         end else begin
            mem_wr_data = {epoch_ff, row_word & ~idx_bit};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpb_pkg::ST_IDLE;
         epoch_ff <= cpb_pkg::TAG_FIRST;
         base_ff <= 1'b0;
         held_ff <= '0;
         sweep_ff <= 1'b1;
         sweep_row_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         epoch_ff <= epoch_in;
         base_ff <= base_in;
         held_ff <= held_in;
         sweep_ff <= sweep_in;
         sweep_row_ff <= sweep_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      cur_row_ff <= cur_row_in;
      first_ff <= first_in;
      is_held_ff <= is_held_in;
      rsp_is_held_ff <= rsp_is_held_in;
      rsp_held_total_ff <= rsp_held_total_in;
      rsp_next_missing_ff <= rsp_next_missing_in;
   end

   // Bitmap memory, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_q_ff <= mem[mem_rd_addr];
      end
   end

endmodule
